[rtl/gbci_pkg.sv]
// ----------------------------------------------------------------------------
// gbci_pkg
// Shared widths, codes, state type and controller/datapath bundles for the
// gyro bias calibration and rate integration core.
// ----------------------------------------------------------------------------
package gbci_pkg;

    localparam int RAW_W       = 16;
    localparam int RATE_W      = 17;
    localparam int ANG_W       = 48;
    localparam int CFG_W       = 10;
    localparam int SCALE_W     = 2 * CFG_W;
    localparam int PROD_W      = RATE_W + SCALE_W + 1;
    localparam int CMD_W       = 2;
    localparam int AXES        = 3;
    localparam int AXIS_W      = 2;
    localparam int STEP_W      = 2;
    localparam int IN_TDATA_W  = AXES * RAW_W;
    localparam int IN_TUSER_W  = CMD_W + 2;
    localparam int OUT_TDATA_W = 200;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_IDX_W   = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CAL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_MS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SENS    = 2'd1;

    localparam logic [CFG_W-1:0] STEP_MS_RESET = 10'd10;
    localparam logic [CFG_W-1:0] SENS_RESET    = 10'd35;

    localparam logic [ANG_W-1:0] ANG_MAX = {1'b0, {(ANG_W-1){1'b1}}};
    localparam logic [ANG_W-1:0] ANG_MIN = {1'b1, {(ANG_W-1){1'b0}}};

    // integrate pass: multiply on steps 0..2, accumulate on steps 1..3
    localparam logic [STEP_W-1:0] STEP_LAST = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHOOSE,
        S_INTEG,
        S_DIVGO,
        S_DIVW,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              load;
        logic              choose;
        logic              mul_en;
        logic [AXIS_W-1:0] mul_axis;
        logic              acc_en;
        logic [AXIS_W-1:0] acc_axis;
        logic              div_start;
        logic              out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             run_end;
        logic             div_done;
        logic             out_free;
    } dp_status_t;

endpackage

[rtl/gyro_bias_calibrate_integrate_core.sv]
// ----------------------------------------------------------------------------
// gyro_bias_calibrate_integrate_core
// Three-axis gyro conditioner: bias calibration and saturating rate
// integration into 48-bit angles in eighth-microdegree units.
//
// Usage:
//   Input words arrive on s_t*: command, link and ready flags in s_tuser,
//   the three raw samples in s_tdata. One result word per input leaves on
//   m_t*: three angles and three bias-corrected rates in m_tdata, the held
//   and bias-valid flags in m_tuser. The user writes step_ms and
//   sensitivity_eighths on cfg_* between items; the block does not enforce it.
//   Integrate words pass through the choose state, the four-step integrate
//   pass and the done state; calibrate, clear and ignored words go from
//   choose to done; a calibrate word that ends a run adds the bias division,
//   one axis per cycle. m_tvalid is registered from the result load. The
//   next word is taken once the controller returns to idle, the cycle after
//   the result is loaded, so a word is not taken before the last is done;
//   the three axes share one multiplier.
//   A finished word sits in the output register while the next is taken;
//   a stalled receiver holds the block only when a second result is ready.
//   Reset restores the default step and sensitivity and clears angles,
//   bias, calibration sums and the held sample; no clearing pass follows.
// ----------------------------------------------------------------------------
module gyro_bias_calibrate_integrate_core #(
    parameter int CAL_COUNT = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // raw_x, raw_y, raw_z
    input  logic [gbci_pkg::IN_TDATA_W-1:0]       s_tdata,
    // command, link_ok, data_ready
    input  logic [gbci_pkg::IN_TUSER_W-1:0]       s_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gbci_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gbci_pkg::CFG_W-1:0]            cfg_data,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // angle_x, angle_y, angle_z, rate_x, rate_y, rate_z, zero fill
    output logic [gbci_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // held, bias_valid
    output logic [gbci_pkg::OUT_TUSER_W-1:0]      m_tuser
);
    import gbci_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    gbci_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gbci_dp #(
        .CAL_COUNT (CAL_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

[rtl/gbci_div.sv]
// ----------------------------------------------------------------------------
// gbci_div
// Bias divider: calibration sums over CAL_COUNT, truncated toward zero, by
// reciprocal multiplication of the magnitude, one axis per cycle.
// ----------------------------------------------------------------------------
module gbci_div #(
    parameter int CAL_COUNT = 10,
    localparam int SUM_W = gbci_pkg::RAW_W + $clog2(CAL_COUNT)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [gbci_pkg::AXES-1:0][SUM_W-1:0]  sum,
    output logic                                  done,
    output logic [gbci_pkg::AXES-1:0][gbci_pkg::RAW_W-1:0] quot
);
    import gbci_pkg::*;

    // floor(n / CAL_COUNT) equals (n * RECIP) >> SHIFT for every n below 2**SUM_W
    localparam int     SHIFT    = SUM_W + $clog2(CAL_COUNT);
    localparam int     RECIP_W  = SUM_W + 1;
    localparam int     PROD_Q_W = SUM_W + RECIP_W;
    localparam longint RECIP_L  = ((longint'(1) << SHIFT) + longint'(CAL_COUNT) - 1)
                                  / longint'(CAL_COUNT);
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_L);
    localparam logic [AXIS_W-1:0]  AXIS_LAST = AXIS_W'(AXES - 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [AXIS_W-1:0]             axis_reg, axis_next;
    logic [AXES-1:0][SUM_W-1:0]    mag_reg, mag_next;
    logic [AXES-1:0]               neg_reg, neg_next;
    logic [AXES-1:0][RAW_W-1:0]    quot_reg, quot_next;

    logic [SUM_W-1:0]              mag_sel;
    logic                          neg_sel;
    logic [PROD_Q_W-1:0]           prod;
    logic [RAW_W-1:0]              q_mag;

    always_comb
    begin
        mag_sel = '0;
        neg_sel = 1'b0;
        for (int i = 0; i < AXES; i++)
        begin
            if (axis_reg == AXIS_W'(i))
            begin
                mag_sel = mag_reg[i];
                neg_sel = neg_reg[i];
            end
        end
        prod  = PROD_Q_W'(mag_sel) * PROD_Q_W'(RECIP);
        q_mag = prod[SHIFT +: RAW_W];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        axis_next = axis_reg;
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            axis_next = '0;
            for (int i = 0; i < AXES; i++)
            begin
                neg_next[i] = sum[i][SUM_W-1];
                mag_next[i] = sum[i][SUM_W-1] ? (SUM_W'(0) - sum[i]) : sum[i];
            end
        end
        else if (busy_reg)
        begin
            // restore the sign on the truncated magnitude
            for (int i = 0; i < AXES; i++)
            begin
                if (axis_reg == AXIS_W'(i))
                    quot_next[i] = neg_sel ? (RAW_W'(0) - q_mag) : q_mag;
            end
            if (axis_reg == AXIS_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                axis_next = axis_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            axis_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            axis_reg <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && axis_reg == AXIS_LAST && !start) |=> (done_reg && !busy_reg))
        else $error("divider did not finish after last axis");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");
`endif

endmodule

[rtl/gbci_dp.sv]
// ----------------------------------------------------------------------------
// gbci_dp
// Datapath: input capture, sample choice, bias and calibration sums, shared
// rate-times-scale multiplier, saturating angle accumulators, result register.
// ----------------------------------------------------------------------------
module gbci_dp #(
    parameter int CAL_COUNT = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  gbci_pkg::dp_cmd_t                     cmd,
    output gbci_pkg::dp_status_t                  status,
    input  logic [gbci_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  logic [gbci_pkg::IN_TUSER_W-1:0]       s_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gbci_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gbci_pkg::CFG_W-1:0]            cfg_data,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [gbci_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic [gbci_pkg::OUT_TUSER_W-1:0]      m_tuser
);
    import gbci_pkg::*;

    localparam int SUM_W  = RAW_W + $clog2(CAL_COUNT);
    localparam int CCNT_W = $clog2(CAL_COUNT + 1);
    localparam logic [CCNT_W-1:0] LAST_CNT = CCNT_W'(CAL_COUNT - 1);
    localparam int PAD_W  = OUT_TDATA_W - AXES * (ANG_W + RATE_W);

    // captured word
    logic [CMD_W-1:0]             cmd_reg;
    logic                         link_reg;
    logic                         rdy_reg;
    logic [AXES-1:0][RAW_W-1:0]   raw_reg;

    // block state
    logic [CFG_W-1:0]             step_reg;
    logic [CFG_W-1:0]             sens_reg;
    logic [AXES-1:0][RAW_W-1:0]   last_reg, last_next;
    logic [AXES-1:0][RAW_W-1:0]   bias_reg;
    logic [AXES-1:0][SUM_W-1:0]   cal_sum_reg, cal_sum_next;
    logic [CCNT_W-1:0]            cal_count_reg;
    logic [AXES-1:0][ANG_W-1:0]   angle_reg;
    logic                         bias_done_reg;

    // per-item working registers
    logic [AXES-1:0][RATE_W-1:0]  rate_reg, rate_next;
    logic                         held_reg, held_next;
    logic [SCALE_W-1:0]           scale_reg, scale_next;
    logic signed [PROD_W-1:0]     prod_reg, prod_next;

    // result register
    logic                         m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]       m_tdata_reg;
    logic [OUT_TUSER_W-1:0]       m_tuser_reg;

    logic                         take;
    logic                         cal_start;
    logic [AXES-1:0][RAW_W-1:0]   base_last;
    logic [AXES-1:0][RAW_W-1:0]   sample;
    logic [AXES-1:0][SUM_W-1:0]   sum_base;

    logic signed [RATE_W-1:0]     mul_a;
    logic signed [SCALE_W:0]      mul_b;
    logic [ANG_W-1:0]             angle_sel;
    logic signed [ANG_W:0]        acc_sum;
    logic [ANG_W-1:0]             acc_sat;

    logic                         div_done;
    logic [AXES-1:0][RAW_W-1:0]   div_quot;

    gbci_div #(
        .CAL_COUNT (CAL_COUNT)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .sum   (cal_sum_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // sample choice and per-item results
    always_comb
    begin
        take      = (cmd_reg == CMD_CAL) || (cmd_reg == CMD_INT);
        cal_start = (cmd_reg == CMD_CAL) && (cal_count_reg == '0);
        held_next = take && link_reg && !rdy_reg;
        for (int i = 0; i < AXES; i++)
        begin
            base_last[i] = cal_start ? '0 : last_reg[i];
            if (!link_reg)
                sample[i] = '0;
            else if (rdy_reg)
                sample[i] = raw_reg[i];
            else
                sample[i] = base_last[i];
            last_next[i] = (take && link_reg && rdy_reg) ? raw_reg[i] : base_last[i];
            rate_next[i] = take ? (RATE_W'($signed(sample[i])) - RATE_W'($signed(bias_reg[i])))
                                : '0;
            sum_base[i]     = cal_start ? '0 : cal_sum_reg[i];
            cal_sum_next[i] = sum_base[i] + SUM_W'($signed(sample[i]));
        end
        scale_next = SCALE_W'(step_reg) * SCALE_W'(sens_reg);
    end

    // shared multiplier and accumulator
    always_comb
    begin
        case (cmd.mul_axis)
            2'd0:    mul_a = $signed(rate_reg[0]);
            2'd1:    mul_a = $signed(rate_reg[1]);
            2'd2:    mul_a = $signed(rate_reg[2]);
            default: mul_a = '0;
        endcase
        mul_b     = $signed({1'b0, scale_reg});
        prod_next = mul_a * mul_b;

        case (cmd.acc_axis)
            2'd0:    angle_sel = angle_reg[0];
            2'd1:    angle_sel = angle_reg[1];
            2'd2:    angle_sel = angle_reg[2];
            default: angle_sel = '0;
        endcase
        acc_sum = $signed({angle_sel[ANG_W-1], angle_sel}) + (ANG_W + 1)'(prod_reg);
        if (acc_sum[ANG_W] != acc_sum[ANG_W-1])
            acc_sat = acc_sum[ANG_W] ? ANG_MIN : ANG_MAX;
        else
            acc_sat = acc_sum[ANG_W-1:0];
    end

    // control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_MS_RESET;
            sens_reg      <= SENS_RESET;
            last_reg      <= '0;
            bias_reg      <= '0;
            cal_sum_reg   <= '0;
            cal_count_reg <= '0;
            angle_reg     <= '0;
            bias_done_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_STEP_MS: step_reg <= cfg_data;
                    REG_SENS:    sens_reg <= cfg_data;
                    default:     ;
                endcase
            end
            if (cmd.choose)
            begin
                last_reg <= last_next;
                if (cmd_reg == CMD_CAL)
                begin
                    cal_sum_reg   <= cal_sum_next;
                    cal_count_reg <= (cal_count_reg == LAST_CNT) ? '0
                                                                 : cal_count_reg + 1'b1;
                end
                if (cmd_reg == CMD_CLR)
                    angle_reg <= '0;
            end
            if (cmd.acc_en)
            begin
                case (cmd.acc_axis)
                    2'd0:    angle_reg[0] <= acc_sat;
                    2'd1:    angle_reg[1] <= acc_sat;
                    2'd2:    angle_reg[2] <= acc_sat;
                    default: ;
                endcase
            end
            if (div_done)
            begin
                bias_reg      <= div_quot;
                bias_done_reg <= 1'b1;
            end
            if (cmd.out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg  <= s_tuser[CMD_W-1:0];
            link_reg <= s_tuser[CMD_W];
            rdy_reg  <= s_tuser[CMD_W+1];
            raw_reg  <= s_tdata;
        end
        if (cmd.choose)
        begin
            rate_reg  <= rate_next;
            held_reg  <= held_next;
            scale_reg <= scale_next;
        end
        if (cmd.mul_en)
            prod_reg <= prod_next;
        if (cmd.out_load)
        begin
            m_tdata_reg <= {{PAD_W{1'b0}}, rate_reg[2], rate_reg[1], rate_reg[0],
                            angle_reg[2], angle_reg[1], angle_reg[0]};
            m_tuser_reg <= {bias_done_reg, held_reg};
        end
    end

    assign cfg_ready        = 1'b1;
    assign m_tvalid         = m_tvalid_reg;
    assign m_tdata          = m_tdata_reg;
    assign m_tuser          = m_tuser_reg;

    assign status.command  = cmd_reg;
    assign status.run_end  = (cmd_reg == CMD_CAL) && (cal_count_reg == LAST_CNT);
    assign status.div_done = div_done;
    assign status.out_free = !m_tvalid_reg || m_tready;

`ifndef ASSERT_OFF
    a_cal_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cal_count_reg <= LAST_CNT)
        else $error("calibration count past run length");
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten before it was taken");
`endif

endmodule

[rtl/gbci_ctrl.sv]
// ----------------------------------------------------------------------------
// gbci_ctrl
// Controller: sequences capture, sample choice, the integrate pass over three
// axes, the bias division at the end of a calibration run and the result load.
// ----------------------------------------------------------------------------
module gbci_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  gbci_pkg::dp_status_t  status,
    output gbci_pkg::dp_cmd_t     cmd
);
    import gbci_pkg::*;

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_CHOOSE;
            end
            S_CHOOSE:
            begin
                case (status.command)
                    CMD_INT: state_next = S_INTEG;
                    CMD_CAL: state_next = status.run_end ? S_DIVGO : S_DONE;
                    default: state_next = S_DONE;
                endcase
            end
            S_INTEG:
            begin
                if (step_reg == STEP_LAST)
                    state_next = S_DONE;
            end
            S_DIVGO:
            begin
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (status.div_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready  = 1'b0;
        cmd       = '0;
        step_next = '0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_CHOOSE:
            begin
                cmd.choose = 1'b1;
            end
            S_INTEG:
            begin
                // multiply axis n while accumulating axis n-1
                cmd.mul_en   = (step_reg != STEP_LAST);
                cmd.mul_axis = step_reg;
                cmd.acc_en   = (step_reg != '0);
                cmd.acc_axis = step_reg - 1'b1;
                step_next    = step_reg + 1'b1;
            end
            S_DIVGO:
            begin
                cmd.div_start = 1'b1;
            end
            S_DONE:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

`ifndef ASSERT_OFF
    a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == S_DIVW))
        else $error("bias division finished outside its wait state");
`endif

endmodule

[dv/gyro_bias_calibrate_integrate_core_tb.sv]
// ----------------------------------------------------------------------------
// gyro_bias_calibrate_integrate_core_tb
// Self-checking bench for the gyro conditioner. A tracker class follows the
// sample choice, bias calibration and saturating integration of the core.
// For every accepted input word it queues the expected result word and
// compares each result word, field by field, against the oldest entry.
// A short directed run comes first. Random runs follow under four
// handshake regimes and several step/sensitivity settings.
// ----------------------------------------------------------------------------
module gyro_bias_calibrate_integrate_core_tb;

    import gbci_pkg::*;

    localparam int CAL_N = 10;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_WORDS = 232;
    localparam logic [CMD_W-1:0] CMD_RSV = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [OUT_TDATA_W-1:0] data;
        logic [OUT_TUSER_W-1:0] user;
    } gyro_word_t;

    class angle_rate_tracker;
        logic [CFG_W-1:0] step_ms;
        logic [CFG_W-1:0] sens;
        logic signed [RAW_W-1:0] last_smp[AXES];
        logic signed [RAW_W-1:0] bias[AXES];
        logic signed [21:0] cal_sum[AXES];
        logic [6:0] cal_cnt;
        logic signed [ANG_W-1:0] angle[AXES];
        bit bias_done;
        gyro_word_t pending_results[$];
        int errors;

        function new();
            int a;
            step_ms = STEP_MS_RESET;
            sens = SENS_RESET;
            for (a = 0; a < AXES; a++)
            begin
                last_smp[a] = '0;
                bias[a] = '0;
                cal_sum[a] = '0;
                angle[a] = '0;
            end
            cal_cnt = '0;
            bias_done = 1'b0;
            errors = 0;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_STEP_MS)
                step_ms = val;
            else if (idx == REG_SENS)
                sens = val;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void take_word(logic [CMD_W-1:0] cmd, logic link, logic rdy,
                                logic [IN_TDATA_W-1:0] raw);
            longint smp[AXES];
            longint rate[AXES];
            longint scale;
            longint acc;
            longint hi;
            longint lo;
            bit held;
            gyro_word_t w;
            int a;
            hi = longint'($signed(ANG_MAX));
            lo = longint'($signed(ANG_MIN));
            held = 1'b0;
            for (a = 0; a < AXES; a++)
            begin
                smp[a] = 0;
                rate[a] = 0;
            end
            if (cmd == CMD_CAL || cmd == CMD_INT)
            begin
                // a calibrate word opening a run wipes the sums and held sample
                if (cmd == CMD_CAL && cal_cnt == 0)
                begin
                    for (a = 0; a < AXES; a++)
                    begin
                        cal_sum[a] = '0;
                        last_smp[a] = '0;
                    end
                end
                if (link)
                begin
                    for (a = 0; a < AXES; a++)
                    begin
                        if (rdy)
                            last_smp[a] = $signed(raw[RAW_W*a +: RAW_W]);
                        smp[a] = longint'(last_smp[a]);
                    end
                    held = !rdy;
                end
                for (a = 0; a < AXES; a++)
                    rate[a] = smp[a] - longint'(bias[a]);
                if (cmd == CMD_CAL)
                begin
                    for (a = 0; a < AXES; a++)
                        cal_sum[a] = 22'(longint'(cal_sum[a]) + smp[a]);
                    cal_cnt = 7'(cal_cnt + 1);
                    if (cal_cnt >= CAL_N)
                    begin
                        for (a = 0; a < AXES; a++)
                            bias[a] = RAW_W'(longint'(cal_sum[a]) / CAL_N);
                        bias_done = 1'b1;
                        cal_cnt = '0;
                    end
                end
                else
                begin
                    scale = longint'(sens) * longint'(step_ms);
                    for (a = 0; a < AXES; a++)
                    begin
                        acc = longint'(angle[a]) + rate[a] * scale;
                        if (acc > hi)
                            acc = hi;
                        else if (acc < lo)
                            acc = lo;
                        angle[a] = ANG_W'(acc);
                    end
                end
            end
            else if (cmd == CMD_CLR)
            begin
                for (a = 0; a < AXES; a++)
                    angle[a] = '0;
            end
            w = '0;
            for (a = 0; a < AXES; a++)
            begin
                w.data[ANG_W*a +: ANG_W] = angle[a];
                w.data[AXES*ANG_W + RATE_W*a +: RATE_W] = rate[a][RATE_W-1:0];
            end
            w.user = {bias_done, held};
            pending_results.push_back(w);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void match_result(logic [OUT_TDATA_W-1:0] data,
                                   logic [OUT_TUSER_W-1:0] user);
            gyro_word_t w;
            string axis[AXES];
            int a;
            axis = '{"x", "y", "z"};
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with nothing expected, tdata %h tuser %b",
                         $time, data, user);
                errors++;
                return;
            end
            w = pending_results.pop_front();
            for (a = 0; a < AXES; a++)
            begin
                compare_field({"angle_", axis[a]},
                              longint'($signed(w.data[ANG_W*a +: ANG_W])),
                              longint'($signed(data[ANG_W*a +: ANG_W])));
                compare_field({"rate_", axis[a]},
                              longint'($signed(w.data[AXES*ANG_W + RATE_W*a +: RATE_W])),
                              longint'($signed(data[AXES*ANG_W + RATE_W*a +: RATE_W])));
            end
            compare_field("held", longint'(w.user[0]), longint'(user[0]));
            compare_field("bias_valid", longint'(w.user[1]), longint'(user[1]));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic [IN_TUSER_W-1:0] s_tuser = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;

    int send_idle = 0;
    int recv_stall = 0;
    angle_rate_tracker gyro_track;

    gyro_bias_calibrate_integrate_core #(
        .CAL_COUNT(CAL_N)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        m_tready = ($urandom_range(0, 99) >= recv_stall);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            gyro_track.match_result(m_tdata, m_tuser);
    end

    // hold the word until taken, then advance to the next falling edge
    task automatic send_word(logic [CMD_W-1:0] cmd, logic link, logic rdy,
                             logic [IN_TDATA_W-1:0] raw);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = raw;
        s_tuser = {rdy, link, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        gyro_track.take_word(cmd, link, rdy, raw);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        gyro_track.apply_reg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // drop valid, wait for every result word, then let the core settle
    task automatic drain();
        s_tvalid = 1'b0;
        while (gyro_track.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [RAW_W-1:0] pick_raw();
        case ($urandom_range(0, 15))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return RAW_W'($urandom());
        endcase
    endfunction

    task automatic random_word();
        int pick;
        logic [CMD_W-1:0] cmd;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            cmd = CMD_INT;
        else if (pick < 83)
            cmd = CMD_CAL;
        else if (pick < 93)
            cmd = CMD_CLR;
        else
            cmd = CMD_RSV;
        send_word(cmd, $urandom_range(0, 99) < 88, $urandom_range(0, 99) < 75,
                  {pick_raw(), pick_raw(), pick_raw()});
    endtask

    initial
    begin
        #5_000_000;
        $display("gyro_bias_calibrate_integrate_core_tb: errors");
        $finish;
    end

    initial
    begin
        gyro_track = new();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, every command, held and dead-link samples
        send_word(CMD_INT, 1'b1, 1'b1, {16'h0000, 16'h8000, 16'h7FFF});
        send_word(CMD_INT, 1'b1, 1'b0, {16'h1234, 16'h5678, 16'h9ABC});
        send_word(CMD_INT, 1'b0, 1'b1, {16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_word(CMD_RSV, 1'b1, 1'b1, {16'h7FFF, 16'h7FFF, 16'h7FFF});
        send_word(CMD_CLR, 1'b1, 1'b1, {16'h8000, 16'h8000, 16'h8000});
        // opening calibrate word with no fresh data reuses the wiped sample
        send_word(CMD_CAL, 1'b1, 1'b0, {16'h7FFF, 16'h7FFF, 16'h7FFF});
        send_word(CMD_CAL, 1'b1, 1'b1, {16'h7FFF, 16'h8000, 16'h0001});
        send_word(CMD_CAL, 1'b1, 1'b1, {16'h7FFF, 16'h8000, 16'hFFFF});
        send_word(CMD_CAL, 1'b0, 1'b1, {16'h7FFF, 16'h8000, 16'hFFFF});
        send_word(CMD_CAL, 1'b1, 1'b0, {16'h0000, 16'h0000, 16'h0000});
        send_word(CMD_INT, 1'b1, 1'b1, {16'h4000, 16'hC000, 16'h0003});
        send_word(CMD_CAL, 1'b1, 1'b1, {16'h7FFF, 16'h8000, 16'hFFFD});
        send_word(CMD_CAL, 1'b1, 1'b1, {16'h7FFF, 16'h8000, 16'hFFFF});
        send_word(CMD_CAL, 1'b1, 1'b1, {16'h7FFE, 16'h8001, 16'hFFFF});
        send_word(CMD_CAL, 1'b1, 1'b1, {16'h7FFF, 16'h8000, 16'h0000});
        send_word(CMD_CAL, 1'b1, 1'b1, {16'h7FFF, 16'h8000, 16'hFFFF});
        send_word(CMD_INT, 1'b1, 1'b1, {16'hFFFF, 16'h0001, 16'h8000});
        send_word(CMD_INT, 1'b1, 1'b0, {16'h0000, 16'h0000, 16'h0000});
        send_word(CMD_INT, 1'b0, 1'b0, {16'h7FFF, 16'h7FFF, 16'h7FFF});
        send_word(CMD_CLR, 1'b0, 1'b0, '0);
        send_word(CMD_CAL, 1'b1, 1'b1, {16'h0100, 16'hFF00, 16'h0010});
        send_word(CMD_INT, 1'b1, 1'b1, {16'h0100, 16'hFF00, 16'h0010});
        send_word(CMD_CAL, 1'b1, 1'b0, {16'h0000, 16'h0000, 16'h0000});
        send_word(CMD_RSV, 1'b0, 1'b0, '0);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 0;
                    recv_stall = 0;
                    write_reg(REG_STEP_MS, 10'd1000);
                    write_reg(REG_SENS, 10'd1023);
                end
                1:
                begin
                    send_idle = 72;
                    recv_stall = 0;
                    write_reg(REG_STEP_MS, 10'd1);
                    write_reg(REG_SENS, 10'd1);
                end
                2:
                begin
                    send_idle = 0;
                    recv_stall = 72;
                    write_reg(REG_STEP_MS, 10'd0);
                    write_reg(REG_SENS, 10'd1023);
                end
                default:
                begin
                    send_idle = 28;
                    recv_stall = 28;
                    write_reg(REG_STEP_MS, CFG_W'($urandom_range(1, 1000)));
                    write_reg(REG_SENS, 10'd0);
                    write_reg(REG_SPARE, CFG_W'($urandom()));
                    write_reg(REG_SENS, CFG_W'($urandom_range(1, 1023)));
                end
            endcase
            repeat (RANDOM_WORDS) random_word();
            drain();
        end

        if (gyro_track.pending() != 0)
        begin
            $display("%0t: %0d expected result words never arrived",
                     $time, gyro_track.pending());
            gyro_track.errors++;
        end
        if (gyro_track.errors == 0)
            $display("gyro_bias_calibrate_integrate_core_tb: clean");
        else
            $display("gyro_bias_calibrate_integrate_core_tb: errors");
        $finish;
    end

endmodule
